// ===== hdl/saf_pkg.sv =====
// shared types and constants of the seasonal arma filter
`timescale 1ns / 1ps
`default_nettype none

package saf_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 18;
    localparam int FRAC_W     = 16;
    localparam int NCOEF      = 4;
    localparam int TAP_W      = 2;
    localparam int CNT_W      = 3;
    localparam int ORDER_W    = 3;
    localparam int SEASON_W   = 5;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int PROD_W     = COEF_W + SAMPLE_W;
    localparam int ACC_W      = PROD_W + 4;

    localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MA_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEASON  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_3  = 3'd6;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    typedef struct packed {
        logic             start;
        logic             issue;
        logic [TAP_W-1:0] tap;
        logic             push;
        logic             clear;
        logic             finish;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] n_taps;
        logic             busy;
        logic             out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== hdl/saf_in_if.sv =====
// input channel: operation and sample
`timescale 1ns / 1ps
`default_nettype none

interface saf_in_if;
    import saf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic signed [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output operation, output sample_value, input ready);
    modport sink   (input valid, input operation, input sample_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/saf_out_if.sv =====
// output channel: filtered value and saturation flag
`timescale 1ns / 1ps
`default_nettype none

interface saf_out_if;
    import saf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] result_value;
    logic                       saturated;

    modport source (output valid, output result_value, output saturated, input ready);
    modport sink   (input valid, input result_value, input saturated, output ready);
endinterface

`default_nettype wire

// ===== hdl/seasonal_arma_filter.sv =====
// top level of the seasonal autoregressive / moving average filter
`timescale 1ns / 1ps
`default_nettype none

// Streams Q7.16 samples through a seasonal AR or MA operator with up to four
// Q1.16 coefficients at lags season, 2*season, and so on. A filter transaction
// gives one rounded, saturated result; push and clear transactions update the
// history and give none. In a filter transaction one shared multiplier walks
// the history taps in use through the single read port of the history
// memory, then the sum is rounded, and the result, or in MA mode the input
// sample, is written back. Results sit in an output register, so the next
// transaction is taken while a result still waits. History holds TAPS*MAX_SEASON
// entries and a fill mark beside the write pointer, so reset and clear take
// effect at once.
module seasonal_arma_filter #(
    parameter int TAPS       = 4,
    parameter int MAX_SEASON = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [saf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [saf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    saf_in_if.sink                                 i_in,
    saf_out_if.source                              o_out
);
    import saf_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    saf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_op     (i_in.operation),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    saf_dp #(
        .TAPS       (TAPS),
        .MAX_SEASON (MAX_SEASON)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_sample    (i_in.sample_value),
        .o_out_vld   (o_out.valid),
        .i_out_rdy   (o_out.ready),
        .o_result    (o_out.result_value),
        .o_saturated (o_out.saturated)
    );
endmodule

`default_nettype wire

// ===== hdl/saf_ram.sv =====
// generic single-write single-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module saf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic [WIDTH-1:0]   i_wdata,
    input  wire logic [AW-1:0]      i_raddr,
    output logic      [WIDTH-1:0]   o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

// ===== hdl/saf_ctrl.sv =====
// controller state machine of the seasonal arma filter
`timescale 1ns / 1ps
`default_nettype none

module saf_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [saf_pkg::OP_W-1:0] i_op,
    input  wire saf_pkg::t_status         i_status,
    output saf_pkg::t_cmd                 o_cmd
);
    import saf_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.tap = TAP_W'(r_cnt);
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (i_op)
                        OP_FILTER: begin
                            o_cmd.start = 1'b1;
                            n_cnt       = '0;
                            n_state     = (i_status.n_taps == '0) ? S_DRAIN : S_ISSUE;
                        end
                        OP_PUSH:  o_cmd.push  = 1'b1;
                        OP_CLEAR: o_cmd.clear = 1'b1;
                        default:  ;
                    endcase
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (r_cnt == CNT_W'(i_status.n_taps - 1'b1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_status.busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

`default_nettype wire

// ===== hdl/saf_dp.sv =====
// datapath: config registers, history, multiply-accumulate, rounding, output register
`timescale 1ns / 1ps
`default_nettype none

module saf_dp #(
    parameter int TAPS       = 4,
    parameter int MAX_SEASON = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [saf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [saf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire saf_pkg::t_cmd                       i_cmd,
    output saf_pkg::t_status                         o_status,
    input  wire logic signed [saf_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                     o_out_vld,
    input  wire logic                                i_out_rdy,
    output logic signed [saf_pkg::SAMPLE_W-1:0]      o_result,
    output logic                                     o_saturated
);
    import saf_pkg::*;

    localparam int DEPTH  = TAPS * MAX_SEASON;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LAG_W  = $clog2(DEPTH + 1);
    localparam int MS_W   = $clog2(MAX_SEASON + 1);
    localparam int CMP_W  = ((MS_W > SEASON_W) ? MS_W : SEASON_W) + 1;
    localparam int NMAX   = (TAPS < NCOEF) ? TAPS : NCOEF;
    localparam int RND_W  = ACC_W - FRAC_W;
    localparam int HI_W   = ACC_W - FRAC_W - SAMPLE_W + 1;

    // configuration
    logic                     r_ma_mode;
    logic [ORDER_W-1:0]       r_order;
    logic [SEASON_W-1:0]      r_season;
    logic signed [COEF_W-1:0] r_coef [NCOEF];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ma_mode <= 1'b0;
            r_order   <= '0;
            r_season  <= SEASON_W'(1);
            for (int k = 0; k < NCOEF; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MA_MODE: r_ma_mode <= i_cfg_data[0];
                REG_ORDER:   r_order   <= i_cfg_data[ORDER_W-1:0];
                REG_SEASON:  r_season  <= i_cfg_data[SEASON_W-1:0];
                REG_COEF_0:  r_coef[0] <= i_cfg_data[COEF_W-1:0];
                REG_COEF_1:  r_coef[1] <= i_cfg_data[COEF_W-1:0];
                REG_COEF_2:  r_coef[2] <= i_cfg_data[COEF_W-1:0];
                REG_COEF_3:  r_coef[3] <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // effective season and tap count
    logic [CMP_W-1:0] w_season_ext;
    logic [MS_W-1:0]  w_s;
    logic [CNT_W-1:0] w_n;

    always_comb begin
        w_season_ext = CMP_W'(r_season);
        if (r_season == '0) begin
            w_s = MS_W'(1);
        end else if (w_season_ext > CMP_W'(MAX_SEASON)) begin
            w_s = MS_W'(MAX_SEASON);
        end else begin
            w_s = MS_W'(w_season_ext);
        end
        w_n = (r_order > CNT_W'(NMAX)) ? CNT_W'(NMAX) : CNT_W'(r_order);
    end

    // history addressing
    logic [PTR_W-1:0]  r_wp;
    logic              r_full;
    logic [LAG_W-1:0]  r_lag;
    logic [LAG_W:0]    w_wp_ext;
    logic [PTR_W-1:0]  w_raddr;
    logic              w_we;
    logic [SAMPLE_W-1:0] w_wdata;
    logic [SAMPLE_W-1:0] w_rdata;

    always_comb begin
        w_wp_ext = (LAG_W + 1)'(r_wp);
        if (w_wp_ext >= (LAG_W + 1)'(r_lag)) begin
            w_raddr = PTR_W'(w_wp_ext - (LAG_W + 1)'(r_lag));
        end else begin
            w_raddr = PTR_W'(w_wp_ext + (LAG_W + 1)'(DEPTH) - (LAG_W + 1)'(r_lag));
        end
    end

    saf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wp),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // rounding and saturation
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_x;
    logic [ACC_W-1:0]           w_sum;
    logic [RND_W-1:0]           w_rnd;
    logic [HI_W-1:0]            w_hi;
    logic                       w_sat_hi, w_sat_lo;
    logic [SAMPLE_W-1:0]        w_res;

    always_comb begin
        w_sum    = r_acc + ACC_W'(1 << (FRAC_W - 1));
        w_rnd    = w_sum[ACC_W-1:FRAC_W];
        w_hi     = w_rnd[RND_W-1:SAMPLE_W-1];
        w_sat_hi = !w_rnd[RND_W-1] && (w_hi != '0);
        w_sat_lo = w_rnd[RND_W-1] && (w_hi != '1);
        if (w_sat_hi) begin
            w_res = SAMPLE_MAX;
        end else if (w_sat_lo) begin
            w_res = SAMPLE_MIN;
        end else begin
            w_res = w_rnd[SAMPLE_W-1:0];
        end
        w_we    = i_cmd.push || i_cmd.finish;
        w_wdata = i_cmd.push ? i_sample : (r_ma_mode ? r_x : w_res);
    end

    // entries below the write pointer, or all once it has wrapped, hold written data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_full <= 1'b0;
        end else if (i_cmd.clear) begin
            r_wp   <= '0;
            r_full <= 1'b0;
        end else if (w_we) begin
            if (r_wp == PTR_W'(DEPTH - 1)) begin
                r_wp   <= '0;
                r_full <= 1'b1;
            end else begin
                r_wp <= r_wp + 1'b1;
            end
        end
    end

    // multiply-accumulate pipeline
    logic                     r_s1_vld, r_s2_vld;
    logic                     r_s1_hit;
    logic [TAP_W-1:0]         r_s1_tap;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SAMPLE_W-1:0] w_hval;

    assign w_hval = r_s1_hit ? w_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_hit <= r_full || (w_raddr < r_wp);
        r_s1_tap <= i_cmd.tap;
        r_prod   <= r_coef[r_s1_tap] * w_hval;
        if (i_cmd.start) begin
            r_x   <= i_sample;
            r_lag <= LAG_W'(w_s);
            r_acc <= {{(ACC_W - SAMPLE_W - FRAC_W){i_sample[SAMPLE_W-1]}}, i_sample,
                      {FRAC_W{1'b0}}};
        end else begin
            if (i_cmd.issue) begin
                r_lag <= r_lag + LAG_W'(w_s);
            end
            if (r_s2_vld) begin
                r_acc <= r_ma_mode ? r_acc - ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            o_out_vld <= 1'b1;
        end else if (i_out_rdy) begin
            o_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_result    <= w_res;
            o_saturated <= w_sat_hi || w_sat_lo;
        end
    end

    always_comb begin
        o_status.n_taps   = w_n;
        o_status.busy     = r_s1_vld || r_s2_vld;
        o_status.out_free = !o_out_vld || i_out_rdy;
    end
endmodule

`default_nettype wire
